// ===== rtl/nearest_lab_color_match_top_defines.svh =====
// Assertion macros shared by the nearest Lab color match RTL.
// Included by modules that carry concurrent checks; needs clk and rst_n in scope.
`ifndef NEAREST_LAB_COLOR_MATCH_TOP_DEFINES_SVH
`define NEAREST_LAB_COLOR_MATCH_TOP_DEFINES_SVH

// Check that is held off while reset is asserted
`define NLCM_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that also holds during reset
`define NLCM_ASSERT_ALL(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/nlcm_pkg.sv =====
// Shared types, widths and the reference Lab color table for the color matcher.
// No dependencies.
package nlcm_pkg;

  // Field widths
  localparam int unsigned L_W      = 17;
  localparam int unsigned AB_W     = 18;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned DE_W     = 19;
  localparam int unsigned DIFF_W   = 19;
  localparam int unsigned SQ_W     = 2 * DIFF_W;
  localparam int unsigned ROM_SIZE = 16;
  localparam int unsigned NUM_REFS_DEF = 16;

  // Output queue
  localparam int unsigned FIFO_DEPTH = 32;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef logic signed [DIFF_W-1:0] comp_t;
  typedef logic [SQ_W-1:0]          sq_t;
  typedef logic [IDX_W-1:0]         idx_t;

  // Candidate in the minimum search; off marks an unused reference slot
  typedef struct packed {
    logic off;
    sq_t  sq;
    idx_t idx;
  } cand_t;

  // Winner handed to the square root pipe
  typedef struct packed {
    sq_t  sq;
    idx_t idx;
  } best_t;

  // Finished result
  typedef struct packed {
    idx_t            idx;
    logic [DE_W-1:0] root;
  } res_t;

  // Reference colors in thousandths: White, Black, Gray, Red, Orange, Yellow,
  // Green, Cyan, Blue, Purple, Magenta, Pink, Brown, Beige, Olive, Navy
  localparam comp_t REF_L [ROM_SIZE] = '{
    19'sd100000, 19'sd0,     19'sd53585, 19'sd54287,
    19'sd70209,  19'sd88712, 19'sd50775, 19'sd66127,
    19'sd31210,  19'sd33024, 19'sd46136, 19'sd72239,
    19'sd33958,  19'sd75232, 19'sd45206, 19'sd13863
  };
  localparam comp_t REF_A [ROM_SIZE] = '{
    19'sd8,      19'sd0,      19'sd5,      19'sd80825,
    19'sd39796,  19'sd519,    -19'sd47200, -19'sd39000,
    19'sd31460,  19'sd47490,  19'sd68848,  19'sd37497,
    19'sd15283,  19'sd6935,   -19'sd8065,  19'sd14539
  };
  localparam comp_t REF_B [ROM_SIZE] = '{
    19'sd4,      19'sd0,      19'sd2,      19'sd69913,
    19'sd76101,  19'sd87379,  19'sd32718,  -19'sd11516,
    -19'sd77889, -19'sd44679, -19'sd16850, -19'sd619,
    19'sd25261,  19'sd24683,  19'sd45507,  -19'sd38182
  };

  // Pick the smaller key; the left (lower index) side wins a tie
  function automatic cand_t pick_min(input cand_t lhs, input cand_t rhs);
    if ({rhs.off, rhs.sq} < {lhs.off, lhs.sq}) begin
      return rhs;
    end
    return lhs;
  endfunction

endpackage

// ===== rtl/nlcm_lane.sv =====
// One distance lane: difference, squares and squared distance to one reference.
// Depends on nlcm_pkg. Three register stages, no stall.
module nlcm_lane (
  input  logic                            clk,
  input  logic [nlcm_pkg::L_W-1:0]        lightness,
  input  logic signed [nlcm_pkg::AB_W-1:0] green_red,
  input  logic signed [nlcm_pkg::AB_W-1:0] blue_yellow,
  input  nlcm_pkg::comp_t                 ref_l,
  input  nlcm_pkg::comp_t                 ref_a,
  input  nlcm_pkg::comp_t                 ref_b,
  output nlcm_pkg::sq_t                   dist_sq
);
  import nlcm_pkg::*;

  comp_t dl_r, da_r, db_r;
  comp_t dl_nxt, da_nxt, db_nxt;
  logic signed [SQ_W-1:0] pl_nxt, pa_nxt, pb_nxt;
  sq_t   pl_r, pa_r, pb_r;
  sq_t   sum_r, sum_nxt;

  // Stage 1: component differences
  always_comb begin
    dl_nxt = $signed({{(DIFF_W-L_W){1'b0}}, lightness}) - ref_l;
    da_nxt = $signed({{(DIFF_W-AB_W){green_red[AB_W-1]}}, green_red}) - ref_a;
    db_nxt = $signed({{(DIFF_W-AB_W){blue_yellow[AB_W-1]}}, blue_yellow}) - ref_b;
  end

  // Stage 2: squares, one multiplier per component
  always_comb begin
    pl_nxt = dl_r * dl_r;
    pa_nxt = da_r * da_r;
    pb_nxt = db_r * db_r;
  end

  // Stage 3: squared distance, each term below 2^36 so no carry out
  assign sum_nxt = pl_r + pa_r + pb_r;

  always_ff @(posedge clk) begin
    dl_r  <= dl_nxt;
    da_r  <= da_nxt;
    db_r  <= db_nxt;
    pl_r  <= sq_t'(pl_nxt);
    pa_r  <= sq_t'(pa_nxt);
    pb_r  <= sq_t'(pb_nxt);
    sum_r <= sum_nxt;
  end

  assign dist_sq = sum_r;

endmodule

// ===== rtl/nlcm_min_tree.sv =====
// Registered minimum tree over the reference candidates, lowest index on ties.
// Depends on nlcm_pkg. Two register stages, two compare levels each.
module nlcm_min_tree (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cand_vld,
  input  nlcm_pkg::cand_t   cands [nlcm_pkg::ROM_SIZE],
  output logic              best_vld,
  output nlcm_pkg::best_t   best
);
  import nlcm_pkg::*;

  localparam int unsigned N1 = ROM_SIZE / 2;
  localparam int unsigned N2 = ROM_SIZE / 4;
  localparam int unsigned N3 = ROM_SIZE / 8;

  cand_t lvl1 [N1];
  cand_t lvl2_nxt [N2];
  cand_t lvl2_r [N2];
  cand_t lvl3 [N3];
  cand_t win_nxt, win_r;
  logic  vld_a_r, vld_b_r;

  // Levels 1 and 2 ahead of the first register
  always_comb begin
    for (int i = 0; i < N1; i++) begin
      lvl1[i] = pick_min(cands[2*i], cands[2*i+1]);
    end
    for (int i = 0; i < N2; i++) begin
      lvl2_nxt[i] = pick_min(lvl1[2*i], lvl1[2*i+1]);
    end
  end

  // Levels 3 and 4 ahead of the second register
  always_comb begin
    for (int i = 0; i < N3; i++) begin
      lvl3[i] = pick_min(lvl2_r[2*i], lvl2_r[2*i+1]);
    end
    win_nxt = pick_min(lvl3[0], lvl3[1]);
  end

  always_ff @(posedge clk) begin
    lvl2_r <= lvl2_nxt;
    win_r  <= win_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else begin
      vld_a_r <= cand_vld;
      vld_b_r <= vld_a_r;
    end
  end

  assign best_vld = vld_b_r;
  assign best.sq  = win_r.sq;
  assign best.idx = win_r.idx;

endmodule

// ===== rtl/nlcm_isqrt.sv =====
// Pipelined floor square root, one result bit per stage, index carried along.
// Depends on nlcm_pkg. DE_W register stages.
module nlcm_isqrt (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            best_vld,
  input  nlcm_pkg::best_t best,
  output logic            res_vld,
  output nlcm_pkg::res_t  res
);
  import nlcm_pkg::*;

  localparam int unsigned TRIAL_W = SQ_W + 2;

  // Stage boundaries: entry 0 is the input, entry s+1 the register of stage s
  logic [SQ_W-1:0] stg_rem  [DE_W+1];
  logic [DE_W-1:0] stg_root [DE_W+1];
  idx_t            stg_idx  [DE_W+1];
  logic            stg_vld  [DE_W+1];

  assign stg_rem[0]  = best.sq;
  assign stg_root[0] = '0;
  assign stg_idx[0]  = best.idx;
  assign stg_vld[0]  = best_vld;

  for (genvar s = 0; s < DE_W; s++) begin : g_stage
    localparam int unsigned BIT = DE_W - 1 - s;

    logic [TRIAL_W-1:0] trial, rem_ext;
    logic [SQ_W-1:0]    rem_r, rem_nxt;
    logic [DE_W-1:0]    root_r, root_nxt;
    idx_t               idx_r;
    logic               vld_r;

    // rem holds sq - root^2; setting bit BIT adds root*2^(BIT+1) + 2^(2*BIT)
    always_comb begin
      rem_ext = {{(TRIAL_W-SQ_W){1'b0}}, stg_rem[s]};
      trial   = ({{(TRIAL_W-DE_W){1'b0}}, stg_root[s]} << (BIT + 1))
              + (TRIAL_W'(1) << (2 * BIT));
      if (rem_ext >= trial) begin
        rem_nxt  = SQ_W'(rem_ext - trial);
        root_nxt = stg_root[s] | (DE_W'(1) << BIT);
      end else begin
        rem_nxt  = stg_rem[s];
        root_nxt = stg_root[s];
      end
    end

    always_ff @(posedge clk) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      idx_r  <= stg_idx[s];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else begin
        vld_r <= stg_vld[s];
      end
    end

    assign stg_rem[s+1]  = rem_r;
    assign stg_root[s+1] = root_r;
    assign stg_idx[s+1]  = idx_r;
    assign stg_vld[s+1]  = vld_r;
  end

  assign res_vld  = stg_vld[DE_W];
  assign res.idx  = stg_idx[DE_W];
  assign res.root = stg_root[DE_W];

endmodule

// ===== rtl/nearest_lab_color_match_top.sv =====
// Nearest reference color match in CIELAB with CIE76 delta E, top level.
// Depends on nlcm_pkg, nlcm_lane, nlcm_min_tree, nlcm_isqrt and the defines header.
//
//  channel | ports                                         | direction
//  --------+-----------------------------------------------+----------
//  input   | in_valid, in_ready, in_lightness,             | in
//          | in_green_red, in_blue_yellow                  |
//  result  | out_valid, out_ready, out_color_index,        | out
//          | out_delta_e                                   |
//
// One transfer per cycle in each direction, as far as in_ready, out_valid and
// out_ready allow; an input passes the distance lanes, the minimum tree and the
// bit-per-stage square root, then the output queue, on its way to the result.
// The compute pipe never stalls; a 32-entry output queue absorbs results and
// in_ready is held low only while 32 items are accepted but not yet delivered.
// rst_n is synchronous, active low, and clears valid bits, pointers and credits.
module nearest_lab_color_match_top #(
  parameter int unsigned NUM_REFERENCES = nlcm_pkg::NUM_REFS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [nlcm_pkg::L_W-1:0]          in_lightness,
  input  logic signed [nlcm_pkg::AB_W-1:0]  in_green_red,
  input  logic signed [nlcm_pkg::AB_W-1:0]  in_blue_yellow,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [nlcm_pkg::IDX_W-1:0]        out_color_index,
  output logic [nlcm_pkg::DE_W-1:0]         out_delta_e
);
  import nlcm_pkg::*;

  `include "nearest_lab_color_match_top_defines.svh"

  localparam int unsigned LANE_STAGES = 3;
  localparam int unsigned CNT_W = FIFO_AW + 1;

  logic              in_xfer, out_xfer;
  logic              lane_vld_r [LANE_STAGES];
  cand_t             cands [ROM_SIZE];
  logic              best_vld;
  best_t             best;
  logic              res_vld;
  res_t              res;
  res_t              fifo_mem [FIFO_DEPTH];
  logic [CNT_W-1:0]  wr_ptr_r, rd_ptr_r, wr_ptr_nxt, rd_ptr_nxt;
  logic [CNT_W-1:0]  credit_r, credit_nxt;
  logic [CNT_W-1:0]  fifo_occ;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // Distance lanes, one per searched reference; unused slots never win
  for (genvar i = 0; i < ROM_SIZE; i++) begin : g_lane
    if (i < NUM_REFERENCES) begin : g_used
      sq_t dist_sq;
      nlcm_lane u_lane (
        .clk         (clk),
        .lightness   (in_lightness),
        .green_red   (in_green_red),
        .blue_yellow (in_blue_yellow),
        .ref_l       (REF_L[i]),
        .ref_a       (REF_A[i]),
        .ref_b       (REF_B[i]),
        .dist_sq     (dist_sq)
      );
      assign cands[i].off = 1'b0;
      assign cands[i].sq  = dist_sq;
      assign cands[i].idx = IDX_W'(i);
    end else begin : g_unused
      assign cands[i].off = 1'b1;
      assign cands[i].sq  = '0;
      assign cands[i].idx = IDX_W'(i);
    end
  end

  // Valid bits alongside the lane stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LANE_STAGES; k++) begin
        lane_vld_r[k] <= 1'b0;
      end
    end else begin
      lane_vld_r[0] <= in_xfer;
      for (int k = 1; k < LANE_STAGES; k++) begin
        lane_vld_r[k] <= lane_vld_r[k-1];
      end
    end
  end

  nlcm_min_tree u_min_tree (
    .clk      (clk),
    .rst_n    (rst_n),
    .cand_vld (lane_vld_r[LANE_STAGES-1]),
    .cands    (cands),
    .best_vld (best_vld),
    .best     (best)
  );

  nlcm_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .best_vld (best_vld),
    .best     (best),
    .res_vld  (res_vld),
    .res      (res)
  );

  // Output queue storage
  always_ff @(posedge clk) begin
    if (res_vld) begin
      fifo_mem[wr_ptr_r[FIFO_AW-1:0]] <= res;
    end
  end

  // Pointers and credits: every accepted item holds one credit until delivered
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + CNT_W'(res_vld);
    rd_ptr_nxt = rd_ptr_r + CNT_W'(out_xfer);
    credit_nxt = credit_r + CNT_W'(in_xfer) - CNT_W'(out_xfer);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      credit_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      credit_r <= credit_nxt;
    end
  end

  assign fifo_occ        = wr_ptr_r - rd_ptr_r;
  assign in_ready        = credit_r < CNT_W'(FIFO_DEPTH);
  assign out_valid       = wr_ptr_r != rd_ptr_r;
  assign out_color_index = fifo_mem[rd_ptr_r[FIFO_AW-1:0]].idx;
  assign out_delta_e     = fifo_mem[rd_ptr_r[FIFO_AW-1:0]].root;

  // Checks on queue and credit bookkeeping
  `NLCM_ASSERT_RST(a_no_overflow, res_vld |-> (fifo_occ < CNT_W'(FIFO_DEPTH)),
                   "result written into a full output queue")
  `NLCM_ASSERT_RST(a_credit_covers_queue, credit_r >= fifo_occ,
                   "queued results exceed outstanding credits")
  `NLCM_ASSERT_RST(a_credit_bound, credit_r <= CNT_W'(FIFO_DEPTH),
                   "credit count beyond queue depth")
  `NLCM_ASSERT_RST(a_out_needs_credit, out_xfer |-> (credit_r != '0),
                   "result delivered with no item outstanding")

endmodule
